FILE: sv/kfe_pkg.sv
// kfe_pkg: shared types, constants and cipher functions of the key fob frame encoder
// used by kfe_round_cell, kfe_frame_pack and keyfob_frame_encrypt; no dependencies
package kfe_pkg;

  localparam int unsigned NumLoad   = 32;
  localparam int unsigned NumFeed   = 32;
  localparam int unsigned NumRounds = NumLoad + NumFeed;

  // filter and feedback constants of the cipher
  localparam logic [15:0] LutA   = 16'h2C79;
  localparam logic [15:0] LutB   = 16'h6671;
  localparam logic [31:0] FiltC  = 32'h7907287B;
  localparam logic [47:0] FbTaps = 48'hB38083220073;

  // configuration register indexes
  localparam logic CfgSerial = 1'b0;
  localparam logic CfgSeed   = 1'b1;

  typedef struct packed {
    logic [15:0] counter;
    logic [3:0]  button;
  } kfe_in_t;

  typedef struct packed {
    logic [63:0] frame_head;
    logic [23:0] frame_tail;
    logic [31:0] iv_word;
  } kfe_out_t;

  // what one round stage holds
  typedef struct packed {
    logic [47:0] st;
    logic [31:0] w;
    logic [31:0] orig;
  } kfe_round_t;

  // nonlinear filter over the 48-bit state
  function automatic logic nlf(logic [47:0] st);
    logic [4:0] g;
    g[0] = LutA[{st[41], st[42], st[44], st[45]}];
    g[1] = LutB[{st[32], st[33], st[35], st[39]}];
    g[2] = LutB[{st[21], st[24], st[26], st[30]}];
    g[3] = LutB[{st[14], st[16], st[18], st[19]}];
    g[4] = LutA[{st[1], st[3], st[4], st[13]}];
    return FiltC[g];
  endfunction

  // linear feedback parity
  function automatic logic lfb(logic [47:0] st);
    return ^(st & FbTaps);
  endfunction

endpackage

FILE: sv/kfe_round_cell.sv
// kfe_round_cell: one registered cipher round, load (iv mixing) or feed (keystream)
// depends on kfe_pkg
module kfe_round_cell #(
  parameter bit Feed = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  kfe_pkg::kfe_round_t data_i,
  output logic               vld_o,
  output kfe_pkg::kfe_round_t data_o
);
  import kfe_pkg::*;

  kfe_round_t data_d, data_q;
  logic       vld_q;
  logic       ob;

  always_comb begin
    data_d = data_i;
    ob     = data_i.orig[31];
    if (Feed) begin
      data_d.w  = {data_i.w[30:0], nlf(data_i.st)};
      data_d.st = {data_i.st[46:0], lfb(data_i.st)};
    end else begin
      data_d.st   = {data_i.st[46:0], data_i.w[31] ^ nlf(data_i.st) ^ ob};
      data_d.w    = {data_i.w[30:0], 1'b0};
      data_d.orig = {data_i.orig[30:0], ob};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

FILE: sv/kfe_frame_pack.sv
// kfe_frame_pack: packs serial, counter bits, hop bytes and check byte into the frame
// depends on kfe_pkg
module kfe_frame_pack (
  input  kfe_pkg::kfe_round_t data_i,
  input  logic [31:0]         serial_i,
  output kfe_pkg::kfe_out_t   frame_o
);
  import kfe_pkg::*;

  logic [7:0]  iv0, iv1, iv2, iv3;
  logic [7:0]  iw0, iw1, iw2, iw3;
  logic [7:0]  h0, h1a, h2a, h3a, h4, h1, h2, h3, hx;
  logic [15:0] mix;
  logic [7:0]  fr [11];

  always_comb begin
    // after the load rounds the iv word is back in place
    iv0 = data_i.orig[7:0];
    iv1 = data_i.orig[15:8];
    iv2 = data_i.orig[23:16];
    iv3 = data_i.orig[31:24];
    iw0 = data_i.w[7:0];
    iw1 = data_i.w[15:8];
    iw2 = data_i.w[23:16];
    iw3 = data_i.w[31:24];

    h0  = iw0;
    h1a = {iw1[6:0], h0[7]};
    h2a = {iw2[6:0], iw1[7]};
    hx  = {h1a[6:0], h0[6]};
    h3a = {iw3[6:0], iw2[7]};
    h4  = {data_i.st[6:0], iw3[7]};
    h1  = {h2a[6:0], h1a[7]};
    h2  = {h3a[6:0], h2a[7]};
    h3  = {h4[6:0], h3a[7]};

    mix = {iv2[3:0], iv1, iv0[7:4]};

    fr[0]  = serial_i[31:24];
    fr[1]  = serial_i[23:16];
    fr[2]  = serial_i[15:8];
    fr[3]  = serial_i[7:0];
    fr[4]  = {iv0[3:0], mix[9:6]};
    fr[5]  = {mix[5:0], h3[1:0]};
    fr[6]  = h2;
    fr[7]  = h1;
    fr[8]  = hx;
    fr[9]  = {h0[5:0], 2'b10};
    fr[10] = fr[0] ^ fr[1] ^ fr[2] ^ fr[3] ^ fr[4] ^ fr[5] ^ fr[6] ^ fr[7] ^ fr[8] ^ fr[9];

    frame_o.frame_head = {fr[0], fr[1], fr[2], fr[3], fr[4], fr[5], fr[6], fr[7]};
    frame_o.frame_tail = {fr[8], fr[9], fr[10]};
    frame_o.iv_word    = {iv0, iv1, iv2, iv3};
  end

endmodule

FILE: sv/keyfob_frame_encrypt.sv
// keyfob_frame_encrypt: top level of the remote-key frame encoder
// depends on kfe_pkg, kfe_round_cell and kfe_frame_pack
//
// Builds one 11-byte remote-key frame per (counter, button) transaction. The
// cipher state and working word come from the serial number register through
// a fixed bit permutation, the iv from counter, button and seed. A row of 64
// round stages follows: 32 that clock the iv into the state through the
// nonlinear filter, then 32 that collect keystream bits under linear feedback.
// The last stage feeds the frame packer and an output register. Throughput is
// one transaction per clock while the output is not stalled. The whole row
// advances together, so a stall on the output side holds every stage and
// input ready drops in the same cycle. Configuration writes are taken every
// cycle and must only happen while the pipeline is empty, since the serial
// register is read again at the packer.
module keyfob_frame_encrypt (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  // input transactions
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kfe_pkg::kfe_in_t  in_data_i,
  // result transactions
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kfe_pkg::kfe_out_t out_data_o
);
  import kfe_pkg::*;

  // configuration registers
  logic [31:0] serial_q;
  logic [15:0] seed_q;

  // key derivation
  logic [7:0]  s0, s1, s2, s3;
  logic [7:0]  p0, p1, p2, p3, p4, p5;
  kfe_round_t  load;

  // round stages
  logic [NumRounds-1:0] stage_vld;
  kfe_round_t           stage_data [NumRounds];
  logic                 advance;

  // output stage
  kfe_out_t frame;
  kfe_out_t out_q;
  logic     out_vld_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_q <= '0;
      seed_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSerial: serial_q <= cfg_data_i;
        CfgSeed:   seed_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // fixed permutation of the serial number into state and working word
  always_comb begin
    s0 = serial_q[31:24];
    s1 = serial_q[23:16];
    s2 = serial_q[15:8];
    s3 = serial_q[7:0];

    p0 = ((s0 >> 6) & 8'h02) | ((s1 >> 4) & 8'h08) | (((s0 ^ 8'h10) >> 4) & 8'h01)
       | (~(s0 << 2) & 8'h20) | ((s0 << 5) & 8'h40) | ((s2 << 1) & 8'h80)
       | (~(s2 >> 5) & 8'h04) | (~(s0 >> 2) & 8'h10);
    p1 = ((s1 >> 5) & 8'h01) | (~(s1 >> 3) & 8'h04) | (s0 & 8'h20) | (~(s3 << 3) & 8'h08)
       | (~(s2 << 2) & 8'h10) | (~(s2 << 3) & 8'h40) | 8'h80;
    p2 = ((s0 >> 2) & 8'h01) | ((s0 >> 3) & 8'h02) | (~(s3 >> 2) & 8'h04) | (s1 & 8'h10)
       | (~(s1 << 4) & 8'h20) | (~(s3 << 3) & 8'h40) | 8'h80;
    p3 = ((s0 >> 2) & 8'h02) | ((s1 >> 3) & 8'h08) | (((s2 ^ 8'h20) >> 5) & 8'h01)
       | ((s1 << 5) & 8'h20) | ((s3 << 1) & 8'h40) | (~(s0 >> 3) & 8'h04)
       | (~(s1 >> 3) & 8'h10) | (~(s2 << 6) & 8'h80);
    p4 = ((s3 << 2) & 8'h08) | ((s0 << 4) & 8'h10) | (((s0 ^ 8'h04) >> 2) & 8'h01)
       | (~(s3 >> 1) & 8'h02) | (~(s1 >> 4) & 8'h04) | (~(s0 << 4) & 8'h20)
       | (~(s2 << 6) & 8'h40) | (~(s1 << 3) & 8'h80);
    p5 = ((s3 >> 2) & 8'h10) | ((s2 >> 3) & 8'h02) | (~s0 & 8'h80) | (~(s0 << 3) & 8'h08)
       | ((s0 >> 2) & 8'h10) | (~(s1 << 3) & 8'h20) | ((s3 >> 1) & 8'h40)
       | (~(s1 >> 1) & 8'h04);

    load.st   = {serial_q, p4, p5};
    load.w    = {p3, p2, p1, p0};
    // iv word with iv byte 0 in the low bits, as the load rounds consume it
    load.orig = {seed_q[7:0], seed_q[15:12], in_data_i.counter[15:12],
                 in_data_i.counter[11:4], in_data_i.counter[3:0], in_data_i.button};
  end

  // the row moves whenever the output register is free or being drained
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = advance;

  for (genvar i = 0; i < NumRounds; i++) begin : g_round
    kfe_round_cell #(
      .Feed(i >= NumLoad)
    ) u_round (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (advance),
      .vld_i ((i == 0) ? in_valid_i : stage_vld[(i == 0) ? 0 : i - 1]),
      .data_i((i == 0) ? load : stage_data[(i == 0) ? 0 : i - 1]),
      .vld_o (stage_vld[i]),
      .data_o(stage_data[i])
    );
  end

  kfe_frame_pack u_pack (
    .data_i  (stage_data[NumRounds-1]),
    .serial_i(serial_q),
    .frame_o (frame)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= stage_vld[NumRounds-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= frame;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // an accepted transaction enters the first round stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> stage_vld[0])
    else $error("accepted transaction missing from first round stage");

  // a frame leaving the last round stage lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_vld[NumRounds-1] && advance |=> out_vld_q)
    else $error("frame lost between last round stage and output");

  // a stall holds the row, including the last round stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(stage_vld))
    else $error("round stages moved during a stall");

  // input is only taken when the output side can make room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

endmodule
